FILE: src/multichannel_sliding_median_filter_unit_macros.svh
// assertion macros for the sliding median filter checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef MULTICHANNEL_SLIDING_MEDIAN_FILTER_UNIT_MACROS_SVH
`define MULTICHANNEL_SLIDING_MEDIAN_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define MSMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("msmf same-cycle check failed");

// next-cycle implication
`define MSMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("msmf next-cycle check failed");

`endif

FILE: src/msmf_pkg.sv
// shared constants and types for the sliding median filter
// no dependencies
`timescale 1ns / 1ps

package msmf_pkg;

    localparam int WINDOW_LEN   = 7;
    localparam int NUM_CHANNELS = 4;
    localparam int IO_FIELDS    = 4;
    localparam int SAMPLE_W     = 16;

    localparam int NUM_LANES = (NUM_CHANNELS < IO_FIELDS) ? NUM_CHANNELS : IO_FIELDS;
    localparam int MID_IDX   = (WINDOW_LEN - 1) / 2;
    localparam int RANK_W    = $clog2(WINDOW_LEN);

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic shift;
        logic load;
    } pipe_ctrl_t;

endpackage

FILE: src/msmf_lane.sv
// one channel: sample window shift register and rank-based median select
// depends on msmf_pkg
`timescale 1ns / 1ps

module msmf_lane
    import msmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_ctrl_t ctrl,
    input  sample_t    sample,
    output sample_t    median
);

    sample_t win_reg  [WINDOW_LEN];
    sample_t win_next [WINDOW_LEN];

    always_comb begin
        for (int j = 0; j < WINDOW_LEN - 1; j++) begin
            win_next[j] = win_reg[j + 1];
        end
        win_next[WINDOW_LEN - 1] = sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
                win_reg[j] <= '0;
            end
        end else if (ctrl.shift) begin
            win_reg <= win_next;
        end
    end

    // rank of each element, ties broken by position
    logic [WINDOW_LEN-1:0] below [WINDOW_LEN];
    logic [RANK_W-1:0]     rank  [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] pick;

    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
                if (j == i) begin
                    below[i][j] = 1'b0;
                end else if (j < i) begin
                    below[i][j] = (win_reg[j] <= win_reg[i]);
                end else begin
                    below[i][j] = (win_reg[j] < win_reg[i]);
                end
            end
            rank[i] = RANK_W'($countones(below[i]));
            pick[i] = (rank[i] == RANK_W'(MID_IDX));
        end
    end

    always_comb begin
        median = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            median = median | (pick[i] ? win_reg[i] : '0);
        end
    end

endmodule

FILE: src/msmf_merge.sv
// output register: collects the lane medians into one result transfer
// depends on msmf_pkg
`timescale 1ns / 1ps

module msmf_merge
    import msmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_ctrl_t ctrl,
    input  sample_t    lane_median [NUM_LANES],
    input  logic       m_ready,
    output logic       m_valid,
    output logic       out_ready,
    output sample_t    median_out  [IO_FIELDS]
);

    logic m_valid_reg;
    logic m_valid_next;

    assign out_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        if (ctrl.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    for (genvar f = 0; f < IO_FIELDS; f++) begin : g_field
        if (f < NUM_LANES) begin : g_live
            sample_t med_reg;
            always_ff @(posedge aclk) begin
                if (ctrl.load) begin
                    med_reg <= lane_median[f];
                end
            end
            assign median_out[f] = med_reg;
        end else begin : g_idle
            assign median_out[f] = '0;
        end
    end

endmodule

FILE: src/multichannel_sliding_median_filter_unit.sv
// top level of the four-channel sliding median filter
// depends on msmf_pkg, msmf_lane, msmf_merge
//
//  channel | ports                               | direction
//  input   | s_valid s_ready s_sample_ch0..3     | samples in, one per channel
//  result  | m_valid m_ready m_median_ch0..3     | medians out, one per channel
//
// one transfer per cycle sustained while m_ready does not stall the output
// first stage: window shift, second stage: compare/rank/select into output register
// aresetn (synchronous) clears all windows to zero and empties the pipeline
// a stall on m_ready holds the output; the window stage still takes one more transfer
`timescale 1ns / 1ps

module multichannel_sliding_median_filter_unit
    import msmf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample_ch0,
    input  logic [SAMPLE_W-1:0] s_sample_ch1,
    input  logic [SAMPLE_W-1:0] s_sample_ch2,
    input  logic [SAMPLE_W-1:0] s_sample_ch3,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_median_ch0,
    output logic [SAMPLE_W-1:0] m_median_ch1,
    output logic [SAMPLE_W-1:0] m_median_ch2,
    output logic [SAMPLE_W-1:0] m_median_ch3
);

    sample_t    samples     [IO_FIELDS];
    sample_t    lane_median [NUM_LANES];
    sample_t    median_out  [IO_FIELDS];
    pipe_ctrl_t ctrl;
    logic       out_ready;
    logic       win_valid_reg;
    logic       win_valid_next;

    assign samples[0] = s_sample_ch0;
    assign samples[1] = s_sample_ch1;
    assign samples[2] = s_sample_ch2;
    assign samples[3] = s_sample_ch3;

    assign s_ready    = !win_valid_reg || out_ready;
    assign ctrl.shift = s_valid && s_ready;
    assign ctrl.load  = win_valid_reg && out_ready;

    always_comb begin
        if (ctrl.shift) begin
            win_valid_next = 1'b1;
        end else if (ctrl.load) begin
            win_valid_next = 1'b0;
        end else begin
            win_valid_next = win_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
        end else begin
            win_valid_reg <= win_valid_next;
        end
    end

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        msmf_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .sample  (samples[c]),
            .median  (lane_median[c])
        );
    end

    msmf_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .lane_median (lane_median),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .out_ready   (out_ready),
        .median_out  (median_out)
    );

    assign m_median_ch0 = median_out[0];
    assign m_median_ch1 = median_out[1];
    assign m_median_ch2 = median_out[2];
    assign m_median_ch3 = median_out[3];

endmodule

FILE: src/msmf_checker.sv
// port-level checks for the sliding median filter, bound to the top level
// depends on msmf_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "multichannel_sliding_median_filter_unit_macros.svh"

module msmf_checker
    import msmf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [SAMPLE_W-1:0] s_sample_ch0,
    input logic [SAMPLE_W-1:0] s_sample_ch1,
    input logic [SAMPLE_W-1:0] s_sample_ch2,
    input logic [SAMPLE_W-1:0] s_sample_ch3,
    input logic                m_valid,
    input logic                m_ready,
    input logic [SAMPLE_W-1:0] m_median_ch0,
    input logic [SAMPLE_W-1:0] m_median_ch1,
    input logic [SAMPLE_W-1:0] m_median_ch2,
    input logic [SAMPLE_W-1:0] m_median_ch3
);

    logic [4*SAMPLE_W-1:0] s_samples;
    logic [4*SAMPLE_W-1:0] m_medians;

    assign s_samples = {s_sample_ch3, s_sample_ch2, s_sample_ch1, s_sample_ch0};
    assign m_medians = {m_median_ch3, m_median_ch2, m_median_ch1, m_median_ch0};

    // stalled input transfer holds
    `MSMF_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_samples))

    // stalled result holds
    `MSMF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_medians))

    // empty output side never blocks the input
    `MSMF_ASSERT_SAME(a_ready_when_empty, !m_valid, s_ready)

    // a fresh result comes from a transfer that passed through the window register and then the output register
    `MSMF_ASSERT_SAME(a_result_source, $rose(m_valid), $past(s_valid && s_ready && aresetn, 2))

endmodule

bind multichannel_sliding_median_filter_unit msmf_checker u_msmf_checker (.*);
